// File: hdl/mbps_pkg.sv
// Shared constants and types of the masked byte pattern search unit.
`default_nettype none
package mbps_pkg;

    localparam int MAX_PATTERN_DEF = 16;
    localparam int PAT_BYTES       = 16;
    localparam int CFG_DATA_W      = 64;
    localparam int LEN_CFG_W       = 5;
    localparam int MASK_W          = 16;
    localparam int SEEN_W          = 32;
    localparam int OFFSET_W        = 32;

    localparam logic [MASK_W-1:0]    MASK_RST = '1;
    localparam logic [LEN_CFG_W-1:0] LEN_RST  = LEN_CFG_W'(16);

    typedef enum logic [1:0] {
        CFG_PAT_LOW     = 2'd0,
        CFG_PAT_HIGH    = 2'd1,
        CFG_ENABLE_MASK = 2'd2,
        CFG_PAT_LENGTH  = 2'd3
    } t_cfg_idx;

    typedef logic [CFG_DATA_W-1:0] t_cfg_data;
    typedef logic [OFFSET_W-1:0]   t_offset;

endpackage
`default_nettype wire

// File: hdl/mbps_byte_if.sv
// Input byte channel: one region byte and its end flag per beat.
`default_nettype none
interface mbps_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       region_end;

    modport source (output valid, output data_byte, output region_end, input ready);
    modport sink   (input valid, input data_byte, input region_end, output ready);
endinterface
`default_nettype wire

// File: hdl/mbps_res_if.sv
// Result channel: found flag and match offset per beat.
`default_nettype none
interface mbps_res_if;
    logic                 valid;
    logic                 ready;
    logic                 found;
    mbps_pkg::t_offset    match_offset;

    modport source (output valid, output found, output match_offset, input ready);
    modport sink   (input valid, input found, input match_offset, output ready);
endinterface
`default_nettype wire

// File: hdl/mbps_cfg_if.sv
// Configuration write channel: register index and write data per beat.
`default_nettype none
interface mbps_cfg_if;
    logic                  valid;
    logic                  ready;
    mbps_pkg::t_cfg_idx    index;
    mbps_pkg::t_cfg_data   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// File: hdl/masked_byte_pattern_search_unit.sv
// Masked byte pattern search unit: window shift, parallel compare, result register.
`default_nettype none
// Scans a region streamed one byte per beat and reports the first offset at which
// the pattern (up to 16 bytes, per-byte enable mask, pattern_length bytes in use)
// matches, or one not-found result when the region ends without a match. Each new
// byte is shifted into a MAX_PATTERN-deep window register and all enabled pattern
// bytes are compared in parallel against it, the result landing in an output
// register. A byte is taken every cycle unless that output register holds a
// result that is not being taken. Configuration writes are always accepted and
// must only be issued while no region is in progress.
module masked_byte_pattern_search_unit #(
    parameter int MAX_PATTERN = mbps_pkg::MAX_PATTERN_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    mbps_byte_if.sink  i_byte,
    mbps_res_if.source o_res,
    mbps_cfg_if.sink   i_cfg
);
    import mbps_pkg::*;

    localparam int LEN_W = $clog2(MAX_PATTERN + 1);
    localparam int IDX_W = $clog2(MAX_PATTERN);
    localparam int CHK   = (MAX_PATTERN < PAT_BYTES) ? MAX_PATTERN : PAT_BYTES;

    // configuration
    logic [CFG_DATA_W-1:0]   r_pat_low;
    logic [CFG_DATA_W-1:0]   r_pat_high;
    logic [MASK_W-1:0]       r_mask;
    logic [LEN_CFG_W-1:0]    r_len;

    // region state
    logic [7:0]              r_win [MAX_PATTERN];
    logic [7:0]              n_win [MAX_PATTERN];
    logic [SEEN_W-1:0]       r_seen;
    logic [SEEN_W-1:0]       n_seen;
    logic                    r_reported;

    // result register
    logic                    r_out_valid;
    logic                    r_found;
    t_offset                 r_offset;

    logic [LEN_W-1:0]        len_u;
    logic [2*CFG_DATA_W-1:0] pat;
    logic                    win_hit;
    logic                    match_hit;
    logic                    res_fire;
    logic                    in_acc;
    logic                    cfg_acc;

    assign i_cfg.ready  = 1'b1;
    assign cfg_acc      = i_cfg.valid & i_cfg.ready;
    assign i_byte.ready = ~r_out_valid | o_res.ready;
    assign in_acc       = i_byte.valid & i_byte.ready;
    assign pat          = {r_pat_high, r_pat_low};

    always_comb begin
        if (r_len == '0) begin
            len_u = LEN_W'(1);
        end else if (int'(r_len) > MAX_PATTERN) begin
            len_u = LEN_W'(MAX_PATTERN);
        end else begin
            len_u = LEN_W'(r_len);
        end
    end

    always_comb begin
        n_win[0] = i_byte.data_byte;
        for (int j = 1; j < MAX_PATTERN; j++) begin
            n_win[j] = r_win[j-1];
        end
        n_seen = (r_seen == '1) ? r_seen : r_seen + SEEN_W'(1);
    end

    // pattern byte k sits len-1-k bytes back from the newest one
    always_comb begin
        logic [IDX_W-1:0] idx;
        win_hit = 1'b1;
        idx     = '0;
        for (int k = 0; k < CHK; k++) begin
            idx = IDX_W'(int'(len_u) - 1 - k);
            if ((k < int'(len_u)) && r_mask[k] && (n_win[idx] != pat[8*k +: 8])) begin
                win_hit = 1'b0;
            end
        end
    end

    assign match_hit = ~r_reported && (n_seen >= SEEN_W'(len_u)) && win_hit;
    assign res_fire  = match_hit | (i_byte.region_end & ~r_reported);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_low  <= '0;
            r_pat_high <= '0;
            r_mask     <= MASK_RST;
            r_len      <= LEN_RST;
        end else if (cfg_acc) begin
            case (i_cfg.index)
                CFG_PAT_LOW:     r_pat_low  <= i_cfg.data;
                CFG_PAT_HIGH:    r_pat_high <= i_cfg.data;
                CFG_ENABLE_MASK: r_mask     <= i_cfg.data[MASK_W-1:0];
                CFG_PAT_LENGTH:  r_len      <= i_cfg.data[LEN_CFG_W-1:0];
                default: ;
            endcase
        end
    end

    // window needs no reset: only bytes of the current region are ever compared
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_win <= n_win;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen     <= '0;
            r_reported <= 1'b0;
        end else if (in_acc) begin
            if (i_byte.region_end) begin
                r_seen     <= '0;
                r_reported <= 1'b0;
            end else begin
                r_seen     <= n_seen;
                r_reported <= r_reported | match_hit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc && res_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && res_fire) begin
            r_found  <= match_hit;
            r_offset <= match_hit ? (n_seen - SEEN_W'(len_u)) : '0;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.found        = r_found;
    assign o_res.match_offset = r_offset;

    a_notfound_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_found |-> r_offset == '0)
        else $error("not-found result with nonzero offset");

    a_region_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_byte.region_end |=> r_seen == '0 && !r_reported)
        else $error("region state not cleared at region end");

    a_reported_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && !i_byte.region_end && r_reported |=> r_reported)
        else $error("match flag dropped inside a region");

    a_match_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && match_hit && !i_byte.region_end |=> r_reported && r_out_valid && r_found)
        else $error("match not recorded");

endmodule
`default_nettype wire

// File: sim/tb_masked_byte_pattern_search_unit.sv
// Testbench for the masked byte pattern search unit: directed and random region scans.
`timescale 1ns / 1ps
module tb_masked_byte_pattern_search_unit;
    import mbps_pkg::*;

    localparam int WIN         = MAX_PATTERN_DEF;
    localparam int STALL_LIMIT = 5000;

    typedef struct packed {
        logic    found;
        t_offset offset;
    } t_scan_result;

    logic i_clk;
    logic i_rst_n;

    mbps_byte_if byte_ch ();
    mbps_res_if  res_ch ();
    mbps_cfg_if  cfg_ch ();

    masked_byte_pattern_search_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (byte_ch),
        .o_res   (res_ch),
        .i_cfg   (cfg_ch)
    );

    // search model: register copy and region state
    logic [63:0]          pat_low_r;
    logic [63:0]          pat_high_r;
    logic [MASK_W-1:0]    mask_r;
    logic [LEN_CFG_W-1:0] len_r;
    logic [7:0]           recent_bytes [WIN];
    logic [31:0]          region_count;
    bit                   match_done;

    t_scan_result pending_matches [$];

    int send_idle_pct;
    int stall_pct;
    int hold_left;
    int mismatches;
    int bytes_sent;
    int regions_sent;
    int n_found;
    int n_missed;
    int n_writes;
    int quiet_cycles;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic int eff_length();
        int len;
        len = int'(len_r);
        if (len == 0) len = 1;
        if (len > WIN) len = WIN;
        return len;
    endfunction

    function automatic logic [7:0] pattern_byte(int k);
        logic [127:0] pat;
        pat = {pat_high_r, pat_low_r};
        return pat[8*k +: 8];
    endfunction

    function automatic void clear_region();
        for (int k = 0; k < WIN; k++) recent_bytes[k] = 8'h00;
        region_count = '0;
        match_done   = 1'b0;
    endfunction

    // Shift one byte into the window and queue the result it causes, if any.
    function automatic void predict_scan(logic [7:0] b, logic last);
        int           len;
        bit           hit;
        t_scan_result res;
        len = eff_length();
        for (int k = WIN - 1; k > 0; k--) recent_bytes[k] = recent_bytes[k-1];
        recent_bytes[0] = b;
        if (region_count != 32'hFFFF_FFFF) region_count++;
        if (!match_done && region_count >= 32'(len)) begin
            hit = 1'b1;
            // pattern byte k sits len-1-k positions back from the newest byte
            for (int k = 0; k < len; k++)
                if (mask_r[k] && recent_bytes[len-1-k] != pattern_byte(k)) hit = 1'b0;
            if (hit) begin
                res.found  = 1'b1;
                res.offset = region_count - 32'(len);
                pending_matches.push_back(res);
                match_done = 1'b1;
            end
        end
        if (last) begin
            if (!match_done) begin
                res.found  = 1'b0;
                res.offset = '0;
                pending_matches.push_back(res);
            end
            clear_region();
        end
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            byte_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        byte_ch.valid      <= 1'b1;
        byte_ch.data_byte  <= b;
        byte_ch.region_end <= last;
        @(posedge i_clk);
        while (!byte_ch.ready) @(posedge i_clk);
        predict_scan(b, last);
        bytes_sent++;
        if (last) regions_sent++;
    endtask

    task automatic send_region(input logic [7:0] region [$]);
        for (int k = 0; k < region.size(); k++)
            send_byte(region[k], k == region.size() - 1);
    endtask

    // Stop sending and let the block go idle before touching registers.
    task automatic wait_idle();
        byte_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_matches.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input t_cfg_data val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        case (idx)
            CFG_PAT_LOW:     pat_low_r  = val;
            CFG_PAT_HIGH:    pat_high_r = val;
            CFG_ENABLE_MASK: mask_r     = val[MASK_W-1:0];
            CFG_PAT_LENGTH:  len_r      = val[LEN_CFG_W-1:0];
            default: ;
        endcase
        n_writes++;
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_idling(input int mode);
        case (mode % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 51; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 51; end
            default: begin send_idle_pct = 29; stall_pct = 29; end
        endcase
    endtask

    // Reset values: all-zero pattern, full mask, length 16; match lands on the last byte.
    task automatic test_reset_pattern();
        logic [7:0] region [$];
        for (int k = 0; k < 16; k++) region.push_back(8'h00);
        send_region(region);
        wait_idle();
    endtask

    // Length 0 acts as 1; the match is followed by a region end with no result.
    task automatic test_length_zero();
        write_reg(CFG_PAT_LENGTH, 64'd0);
        write_reg(CFG_PAT_LOW, 64'hFF);
        send_region('{8'h00, 8'hFF, 8'hFF});
        wait_idle();
    endtask

    // Length 31 saturates to 16, so a one-byte region cannot match even with all wildcards.
    task automatic test_length_saturate();
        write_reg(CFG_PAT_LENGTH, 64'd31);
        write_reg(CFG_ENABLE_MASK, 64'h0);
        send_region('{8'h81});
        wait_idle();
    endtask

    // Wildcard on byte 0: only byte 1 is checked, at its own offset.
    task automatic test_wildcard_lead();
        write_reg(CFG_PAT_LENGTH, 64'd2);
        write_reg(CFG_ENABLE_MASK, 64'h0002);
        write_reg(CFG_PAT_LOW, 64'h5A00);
        send_region('{8'h12, 8'h34, 8'h5A});
        wait_idle();
    endtask

    // Receiver holds off while one-byte regions keep coming, so the block backs up.
    task automatic test_output_backpressure();
        write_reg(CFG_PAT_LENGTH, 64'd1);
        write_reg(CFG_ENABLE_MASK, 64'h0);
        set_idling(0);
        hold_left = 300;
        for (int k = 0; k < 40; k++) send_byte(8'($urandom), 1'b1);
        wait_idle();
    endtask

    task automatic load_phase_config(input int phase);
        logic [63:0] low_v;
        logic [63:0] high_v;
        logic [15:0] mask_v;
        logic [4:0]  len_v;
        low_v  = {$urandom, $urandom};
        high_v = {$urandom, $urandom};
        mask_v = 16'($urandom) | 16'($urandom);
        len_v  = 5'($urandom_range(0, 31));
        case (phase)
            0: begin len_v = 5'd16; mask_v = 16'hFFFF; end
            1: begin len_v = 5'd1; low_v = '1; high_v = '1; end
            2: begin len_v = 5'd0; low_v = '0; high_v = '0; end
            3: begin len_v = 5'd31; mask_v = 16'h0000; end
            4: begin len_v = 5'd17; mask_v = 16'hFFFF; end
            default: ;
        endcase
        write_reg(CFG_PAT_LOW, low_v);
        write_reg(CFG_PAT_HIGH, high_v);
        write_reg(CFG_ENABLE_MASK, {32'($urandom), 16'($urandom), mask_v});
        write_reg(CFG_PAT_LENGTH, {32'($urandom), 27'($urandom), len_v});
    endtask

    // Mostly regions with the pattern planted at a random start, some with one byte
    // corrupted, the rest plain noise.
    task automatic run_scan_phase(input int n_items);
        logic [7:0] region [$];
        int         len;
        int         eff;
        int         start;
        int         pick;
        int         sent;
        int         k;
        sent = 0;
        eff  = eff_length();
        while (sent < n_items) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(41, 120) : $urandom_range(1, 40);
            region.delete();
            for (k = 0; k < len; k++)
                region.push_back(($urandom_range(1) == 1) ? pattern_byte($urandom_range(15))
                                                          : 8'($urandom));
            pick = $urandom_range(99);
            if (pick < 65 && eff <= len) begin
                start = $urandom_range(len - eff);
                for (k = 0; k < eff; k++)
                    if (mask_r[k]) region[start+k] = pattern_byte(k);
                if (pick < 15) begin
                    k = $urandom_range(eff - 1);
                    if (mask_r[k]) region[start+k] = ~pattern_byte(k);
                end
            end
            send_region(region);
            sent += len;
        end
        wait_idle();
    endtask

    task automatic test_random_scan();
        for (int phase = 0; phase < 8; phase++) begin
            load_phase_config(phase);
            set_idling(phase);
            run_scan_phase(75);
        end
    endtask

    // result sink: checks each beat, then picks ready for the next cycle
    initial begin : result_sink
        t_scan_result want;
        forever begin
            @(posedge i_clk);
            if (res_ch.valid && res_ch.ready) begin
                if (res_ch.found) n_found++;
                else n_missed++;
                if (pending_matches.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: found=%0b offset=%0d",
                                 res_ch.found, res_ch.match_offset);
                end else begin
                    want = pending_matches.pop_front();
                    if (res_ch.found !== want.found || res_ch.match_offset !== want.offset) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result mismatch: expected found=%0b offset=%0d, got found=%0b offset=%0d",
                                     want.found, want.offset, res_ch.found, res_ch.match_offset);
                    end
                end
            end
            if (hold_left > 0) begin
                res_ch.ready <= 1'b0;
                hold_left--;
            end else begin
                res_ch.ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    initial begin : watchdog
        forever begin
            @(posedge i_clk);
            if ((byte_ch.valid && byte_ch.ready) || (res_ch.valid && res_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("timeout: no beat for %0d cycles", STALL_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n            = 1'b0;
        byte_ch.valid      = 1'b0;
        byte_ch.data_byte  = 8'h00;
        byte_ch.region_end = 1'b0;
        res_ch.ready       = 1'b0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.index       = CFG_PAT_LOW;
        cfg_ch.data        = '0;
        pat_low_r          = '0;
        pat_high_r         = '0;
        mask_r             = MASK_RST;
        len_r              = LEN_RST;
        send_idle_pct      = 0;
        stall_pct          = 0;
        hold_left          = 0;
        mismatches         = 0;
        bytes_sent         = 0;
        regions_sent       = 0;
        n_found            = 0;
        n_missed           = 0;
        n_writes           = 0;
        quiet_cycles       = 0;
        clear_region();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_pattern();
        test_length_zero();
        test_length_saturate();
        test_wildcard_lead();
        test_output_backpressure();
        test_random_scan();

        repeat (8) @(posedge i_clk);
        $display("Scanned %0d bytes in %0d regions: %0d matches, %0d no-match results, %0d writes.",
                 bytes_sent, regions_sent, n_found, n_missed, n_writes);
        $display("Lengths 0 to 31, wildcard masks, output hold-off and four idle mixes exercised.");
        if (mismatches == 0 && pending_matches.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// File: filelist.f
hdl/mbps_pkg.sv
hdl/mbps_byte_if.sv
hdl/mbps_res_if.sv
hdl/mbps_cfg_if.sv
hdl/masked_byte_pattern_search_unit.sv
sim/tb_masked_byte_pattern_search_unit.sv
